FILE: rtl/wud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wud_pkg;

  // Sample and header geometry
  localparam int unsigned SampleW    = 13;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned HdrPosW    = 6;
  localparam int unsigned LenW       = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [HdrPosW-1:0] HdrLast = HdrPosW'(43);
  localparam logic [HdrPosW-1:0] LenPos0 = HdrPosW'(40);

  typedef logic signed [SampleW-1:0] sample_t;

  localparam sample_t SampleMin = -SampleW'(3840);
  localparam sample_t SampleMax = SampleW'(3810);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_BAD    = 2'd1,
    KIND_TRUNC  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_REPEAT,
    TAIL_TRUNC
  } tail_e;

  // One decoded byte, as handed from the parser to the result sequencer
  typedef struct packed {
    logic    is_err;
    kind_e   err_kind;
    logic    has_avg;
    tail_e   tail;
    sample_t prev;
    sample_t cur;
  } job_t;

  // Expected header byte and whether the position is checked
  typedef struct packed {
    logic             checked;
    logic [ByteW-1:0] value;
  } hdr_ref_t;

  function automatic hdr_ref_t hdr_ref(input logic [HdrPosW-1:0] pos);
    hdr_ref_t r;
    r.checked = (pos < HdrPosW'(4)) || ((pos >= HdrPosW'(8)) && (pos < HdrPosW'(12))) ||
                ((pos >= HdrPosW'(16)) && (pos < LenPos0));
    unique case (pos)
      HdrPosW'(0):  r.value = 8'h52;  // R
      HdrPosW'(1):  r.value = 8'h49;  // I
      HdrPosW'(2):  r.value = 8'h46;  // F
      HdrPosW'(3):  r.value = 8'h46;  // F
      HdrPosW'(8):  r.value = 8'h57;  // W
      HdrPosW'(9):  r.value = 8'h41;  // A
      HdrPosW'(10): r.value = 8'h56;  // V
      HdrPosW'(11): r.value = 8'h45;  // E
      HdrPosW'(16): r.value = 8'h10;  // format chunk size
      HdrPosW'(20): r.value = 8'h01;  // PCM
      HdrPosW'(22): r.value = 8'h01;  // mono
      HdrPosW'(24): r.value = 8'h22;  // 22050 Hz
      HdrPosW'(25): r.value = 8'h56;
      HdrPosW'(28): r.value = 8'h22;  // 22050 bytes per second
      HdrPosW'(29): r.value = 8'h56;
      HdrPosW'(32): r.value = 8'h01;  // bytes per frame
      HdrPosW'(34): r.value = 8'h08;  // bits per sample
      HdrPosW'(36): r.value = 8'h64;  // d
      HdrPosW'(37): r.value = 8'h61;  // a
      HdrPosW'(38): r.value = 8'h74;  // t
      HdrPosW'(39): r.value = 8'h61;  // a
      default:      r.value = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wud_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_of_file;
  logic       end_of_file;

  modport source (output valid, file_byte, first_of_file, end_of_file, input ready);
  modport sink   (input valid, file_byte, first_of_file, end_of_file, output ready);
endinterface

`default_nettype wire

FILE: rtl/wud_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wud_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [12:0] sample;
  logic               last_of_run;

  modport source (output valid, result_kind, sample, last_of_run, input ready);
  modport sink   (input valid, result_kind, sample, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/wud_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wud_front (
  input  wire          clk_i,
  input  wire          rst_ni,
  wud_in_if.sink       in_i,
  input  wire          q_full_i,
  output logic         push_o,
  output wud_pkg::job_t job_o
);

  wud_pkg::phase_e                   phase_q, phase_d;
  logic [wud_pkg::HdrPosW-1:0]       pos_q, pos_d;
  logic                              mis_q, mis_d;
  logic [wud_pkg::LenW-1:0]          rem_q, rem_d;
  logic                              first_data_q, first_data_d;
  wud_pkg::sample_t                  prev_q, prev_d;

  logic                              accept;
  logic                              start;
  wud_pkg::phase_e                   cur_phase;
  logic [wud_pkg::HdrPosW-1:0]       pos;
  wud_pkg::hdr_ref_t                 ref_b;
  logic                              mism;
  logic                              hdr_last;
  logic                              len_zero;
  logic                              data_last;
  logic signed [wud_pkg::ByteW-1:0]  centered;
  wud_pkg::sample_t                  cen_ext;
  wud_pkg::sample_t                  cur;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & in_i.ready;

  // Restart parsing on a marked first byte or on any byte while idle
  assign start     = in_i.first_of_file | (phase_q == wud_pkg::PH_IDLE);
  assign cur_phase = start ? wud_pkg::PH_HEADER : phase_q;
  assign pos       = start ? '0 : pos_q;
  assign ref_b     = wud_pkg::hdr_ref(pos);
  assign mism      = (~start & mis_q) | (ref_b.checked & (in_i.file_byte != ref_b.value));
  assign hdr_last  = (pos == wud_pkg::HdrLast);
  assign len_zero  = (rem_q[23:0] == 24'd0) && (in_i.file_byte == 8'd0);
  assign data_last = (rem_q == wud_pkg::LenW'(1));

  // Scale the byte: (b - 128) * 30 as 32x - 2x
  assign centered = {~in_i.file_byte[7], in_i.file_byte[6:0]};
  assign cen_ext  = wud_pkg::sample_t'(centered);
  assign cur      = (cen_ext <<< 5) - (cen_ext <<< 1);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (cur_phase)
        wud_pkg::PH_HEADER: begin
          if (hdr_last) begin
            phase_d = (mism | len_zero | in_i.end_of_file) ? wud_pkg::PH_DONE
                                                           : wud_pkg::PH_DATA;
          end else begin
            phase_d = in_i.end_of_file ? wud_pkg::PH_DONE : wud_pkg::PH_HEADER;
          end
        end
        wud_pkg::PH_DATA: begin
          phase_d = (data_last | in_i.end_of_file) ? wud_pkg::PH_DONE : wud_pkg::PH_DATA;
        end
        wud_pkg::PH_DONE: phase_d = wud_pkg::PH_DONE;
        wud_pkg::PH_IDLE: phase_d = wud_pkg::PH_IDLE;
        default:          phase_d = wud_pkg::PH_IDLE;
      endcase
    end
  end

  // Datapath updates and the job handed to the queue
  always_comb begin
    pos_d        = pos_q;
    mis_d        = mis_q;
    rem_d        = rem_q;
    first_data_d = first_data_q;
    prev_d       = prev_q;
    push_o       = 1'b0;
    job_o        = '0;
    job_o.cur    = cur;
    job_o.prev   = prev_q;
    if (accept) begin
      if (start) begin
        rem_d  = '0;
        prev_d = '0;
      end
      unique case (cur_phase)
        wud_pkg::PH_HEADER: begin
          mis_d = mism;
          pos_d = pos + wud_pkg::HdrPosW'(1);
          if (pos >= wud_pkg::LenPos0) begin
            unique case (pos[1:0])
              2'd0:    rem_d[7:0]   = in_i.file_byte;
              2'd1:    rem_d[15:8]  = in_i.file_byte;
              2'd2:    rem_d[23:16] = in_i.file_byte;
              default: rem_d[31:24] = in_i.file_byte;
            endcase
          end
          first_data_d = 1'b1;
          if (hdr_last) begin
            if (mism | len_zero) begin
              push_o         = 1'b1;
              job_o.is_err   = 1'b1;
              job_o.err_kind = wud_pkg::KIND_BAD;
            end else if (in_i.end_of_file) begin
              push_o         = 1'b1;
              job_o.is_err   = 1'b1;
              job_o.err_kind = wud_pkg::KIND_TRUNC;
            end
          end else if (in_i.end_of_file) begin
            push_o         = 1'b1;
            job_o.is_err   = 1'b1;
            job_o.err_kind = wud_pkg::KIND_BAD;
          end
        end
        wud_pkg::PH_DATA: begin
          push_o        = 1'b1;
          job_o.has_avg = ~first_data_q;
          priority if (data_last)     job_o.tail = wud_pkg::TAIL_REPEAT;
          else if (in_i.end_of_file)  job_o.tail = wud_pkg::TAIL_TRUNC;
          else                        job_o.tail = wud_pkg::TAIL_NONE;
          rem_d        = rem_q - wud_pkg::LenW'(1);
          prev_d       = cur;
          first_data_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= wud_pkg::PH_IDLE;
      pos_q        <= '0;
      mis_q        <= 1'b0;
      rem_q        <= '0;
      first_data_q <= 1'b0;
      prev_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      mis_q        <= mis_d;
      rem_q        <= rem_d;
      first_data_q <= first_data_d;
      prev_q       <= prev_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wud_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wud_queue (
  input  wire                wud_pkg::job_t job_i,
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  wire                pop_i,
  output logic               full_o,
  output logic               valid_o,
  output wud_pkg::job_t      job_o
);

  wud_pkg::job_t                mem_q [wud_pkg::QueueDepth];
  logic [wud_pkg::QPtrW-1:0]    wr_q, wr_d;
  logic [wud_pkg::QPtrW-1:0]    rd_q, rd_d;
  logic [wud_pkg::QCntW-1:0]    cnt_q, cnt_d;
  logic                         do_push;
  logic                         do_pop;

  assign full_o  = (cnt_q == wud_pkg::QCntW'(wud_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == wud_pkg::QPtrW'(wud_pkg::QueueDepth - 1)) ? '0 : wr_q + wud_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == wud_pkg::QPtrW'(wud_pkg::QueueDepth - 1)) ? '0 : rd_q + wud_pkg::QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + wud_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - wud_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wud_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wud_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  wire wud_pkg::job_t q_job_i,
  output logic               pop_o,
  wud_out_if.source          out_o
);

  wud_pkg::job_t              job_q, job_d;
  logic                       job_valid_q, job_valid_d;
  logic [1:0]                 step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  wud_pkg::kind_e             kind_q, kind_d;
  wud_pkg::sample_t           sample_q, sample_d;
  logic                       last_q, last_d;

  logic [1:0]                 n_res;
  logic [1:0]                 slot;
  logic                       load_out;
  logic                       res_last;
  logic                       take;
  logic signed [wud_pkg::SampleW:0] sum;
  logic signed [wud_pkg::SampleW:0] sum_adj;
  wud_pkg::sample_t           avg;
  wud_pkg::kind_e             res_kind;
  wud_pkg::sample_t           res_sample;

  // Average of previous and current sample, truncated toward zero
  assign sum     = {job_q.prev[wud_pkg::SampleW-1], job_q.prev} +
                   {job_q.cur[wud_pkg::SampleW-1], job_q.cur};
  assign sum_adj = sum + {{wud_pkg::SampleW{1'b0}}, sum[wud_pkg::SampleW]};
  assign avg     = sum_adj[wud_pkg::SampleW:1];

  // Number of results for this job and the slot of the current step
  assign n_res = job_q.is_err ? 2'd1
               : 2'd1 + {1'b0, job_q.has_avg} + {1'b0, job_q.tail != wud_pkg::TAIL_NONE};
  assign slot     = step_q + {1'b0, ~job_q.has_avg};
  assign res_last = (step_q == n_res - 2'd1);
  assign load_out = job_valid_q & (~out_valid_q | out_o.ready);
  assign take     = ~job_valid_q | (load_out & res_last);
  assign pop_o    = take & q_valid_i;

  // Pick the result for the current step
  always_comb begin
    res_kind   = wud_pkg::KIND_SAMPLE;
    res_sample = job_q.cur;
    if (job_q.is_err) begin
      res_kind   = job_q.err_kind;
      res_sample = '0;
    end else begin
      unique case (slot)
        2'd0: res_sample = avg;
        2'd1: res_sample = job_q.cur;
        2'd2: begin
          if (job_q.tail == wud_pkg::TAIL_TRUNC) begin
            res_kind   = wud_pkg::KIND_TRUNC;
            res_sample = '0;
          end
        end
        default: res_sample = job_q.cur;
      endcase
    end
  end

  // Step through the job and load the output register
  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    sample_d    = sample_q;
    last_d      = last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      kind_d      = res_kind;
      sample_d    = res_sample;
      last_d      = res_last;
      step_d      = res_last ? 2'd0 : step_q + 2'd1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      job_valid_d = q_valid_i;
      job_d       = q_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    kind_q   <= kind_d;
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.sample      = sample_q;
  assign out_o.last_of_run = last_q;

endmodule

`default_nettype wire

FILE: rtl/wav_u8_mono_decode_upsample2x_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// WAV 8-bit mono decoder with 2x linear upsampling.
// in_i carries one file byte per item with first_of_file and end_of_file
// marks; out_o carries results (result_kind, sample, last_of_run), one per
// item, last_of_run set on the final result caused by an input byte.
// A parser takes bytes, checks the 44-byte header and scales data bytes;
// decoded bytes pass through a two-entry queue to a sequencer that emits
// up to three results per byte (average, sample, repeat or truncation).
// A byte's first result passes the queue, job and output registers in turn.
// Throughput: the sequencer sends one result per cycle while out_o.ready is
// high, so a data byte yields two results (one for the first data byte, one
// more for the final or a cut-short byte). The parser keeps taking bytes
// while the queue has room, so the queue holds up to two result-bearing bytes
// behind the one being sequenced while the receiver stalls.
// When out_o.ready is low the output register holds its result and the
// queue fills, then in_i.ready drops. Reset clears the parser to idle and
// empties the queue and output register; the next byte starts a new file.

module wav_u8_mono_decode_upsample2x_unit (
  input  wire      clk_i,
  input  wire      rst_ni,
  wud_in_if.sink   in_i,
  wud_out_if.source out_o
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;
  wud_pkg::job_t push_job;
  wud_pkg::job_t head_job;

  wud_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  wud_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  wud_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (head_job),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/wud_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wud_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               out_valid_i,
  input wire               out_ready_i,
  input wire [1:0]         out_kind_i,
  input wire signed [12:0] out_sample_i,
  input wire               out_last_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_sample_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Drop valid only after the receiver took the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result dropped without handshake");

  // Error results end their run and carry a zero sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != wud_pkg::KIND_SAMPLE) |-> out_last_i &&
      (out_sample_i == '0))
    else $error("malformed error result");

  // Samples stay within the scaled byte range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == wud_pkg::KIND_SAMPLE) |->
      (out_sample_i >= wud_pkg::SampleMin) && (out_sample_i <= wud_pkg::SampleMax))
    else $error("sample out of range");

endmodule

bind wav_u8_mono_decode_upsample2x_unit wud_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.result_kind),
  .out_sample_i (out_o.sample),
  .out_last_i   (out_o.last_of_run)
);

`default_nettype wire

FILE: dv/wav_u8_mono_decode_upsample2x_unit_tb.sv
`timescale 1ns / 1ps

module wav_u8_mono_decode_upsample2x_unit_tb;
  import wud_pkg::*;

  localparam int HdrBytes    = 44;
  localparam int LenField    = 40;
  localparam int SampleScale = 30;
  localparam int SampleBias  = 128;
  localparam int RateHz      = 22050;
  localparam int NoBad       = -1;
  localparam int RandItems   = 220;
  localparam int RandResults = 60;
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 20;
  localparam int MaxReports  = 10;
  localparam int CycleLimit  = 400000;

  // One result as the decoder should emit it
  typedef struct packed {
    kind_e   kind;
    sample_t smp;
    logic    last;
  } result_t;

  typedef enum logic {ROW_HEADER, ROW_BYTE} row_op_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_mode_e;

  // Directed row: a header row sends header bytes 0..42 (length low bytes from
  // len), the next row supplies byte 43, the length MSB
  typedef struct packed {
    row_op_e    op;
    logic [7:0] b;
    logic       first;
    logic       eof;
    logic [23:0] len;
    int         bad_pos;
    exp_mode_e  mode;
    kind_e      kind;
    int         smp;
  } stim_row_t;

  localparam stim_row_t DirRows [26] = '{
    // byte in idle starts a file; three data bytes, the last one repeated
    '{ROW_HEADER, 8'h00, 1'b0, 1'b0, 24'd3, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 24'd0, NoBad, EXP_NONE,  KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 24'd0, NoBad, EXP_ONE,   KIND_SAMPLE, -3840},
    '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 24'd0, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h80, 1'b0, 1'b0, 24'd0, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    // bytes and end of file after completion are dropped
    '{ROW_BYTE,   8'h5A, 1'b0, 1'b0, 24'd0, NoBad, EXP_NONE,  KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'hA5, 1'b0, 1'b1, 24'd0, NoBad, EXP_NONE,  KIND_SAMPLE, 0},
    // zero length
    '{ROW_HEADER, 8'h00, 1'b1, 1'b0, 24'd0, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 24'd0, NoBad, EXP_ONE,   KIND_BAD,    0},
    // corrupt RIFF tag
    '{ROW_HEADER, 8'h00, 1'b1, 1'b0, 24'd2, 0,     EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 24'd0, NoBad, EXP_ONE,   KIND_BAD,    0},
    // good header ending the file: no data
    '{ROW_HEADER, 8'h00, 1'b1, 1'b0, 24'd4, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b1, 24'd0, NoBad, EXP_ONE,   KIND_TRUNC,  0},
    // data cut short
    '{ROW_HEADER, 8'h00, 1'b1, 1'b0, 24'd5, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 24'd0, NoBad, EXP_NONE,  KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 24'd0, NoBad, EXP_ONE,   KIND_SAMPLE, 3810},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b1, 24'd0, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    // header cut short on its first byte
    '{ROW_BYTE,   8'h40, 1'b1, 1'b1, 24'd0, NoBad, EXP_ONE,   KIND_BAD,    0},
    // all-ones length, then a restart in the middle of the data
    '{ROW_HEADER, 8'h00, 1'b1, 1'b0, 24'hFFFFFF, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 24'd0, NoBad, EXP_NONE,  KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h10, 1'b0, 1'b0, 24'd0, NoBad, EXP_ONE,   KIND_SAMPLE, -3360},
    '{ROW_BYTE,   8'h7F, 1'b0, 1'b0, 24'd0, NoBad, EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h52, 1'b1, 1'b0, 24'd0, NoBad, EXP_NONE,  KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h49, 1'b0, 1'b1, 24'd0, NoBad, EXP_ONE,   KIND_BAD,    0},
    // corrupt data tag
    '{ROW_HEADER, 8'h00, 1'b1, 1'b0, 24'd2, 36,    EXP_MODEL, KIND_SAMPLE, 0},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 24'd0, NoBad, EXP_ONE,   KIND_BAD,    0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  wud_in_if  in_if ();
  wud_out_if out_if ();

  wav_u8_mono_decode_upsample2x_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Decoder state mirror
  phase_e      fsm       = PH_IDLE;
  logic [5:0]  hpos      = '0;
  logic        hbad      = 1'b0;
  logic [31:0] dlen      = '0;
  logic [31:0] dleft     = '0;
  sample_t     prev_smp  = '0;

  result_t     exp_q[$];

  logic calm      = 1'b0;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;

  int errors       = 0;
  int live_bytes   = 0;
  int results_due  = 0;
  int stall_cycles = 0;
  int n_samples    = 0;
  int n_bad        = 0;
  int n_trunc      = 0;
  int cycle_cnt    = 0;

  // Canonical header byte at pos for a file declaring len data bytes
  function automatic logic [7:0] wav_hdr_byte(input int pos, input logic [31:0] len);
    logic [31:0] word;
    case (pos >> 2)
      0:       word = 32'h4646_4952;      // RIFF
      1:       word = len + 32'd36;       // chunk size, not checked
      2:       word = 32'h4556_4157;      // WAVE
      3:       word = 32'h2074_6D66;      // fmt tag, not checked
      4:       word = 32'd16;
      5:       word = 32'h0001_0001;      // PCM, mono
      6:       word = 32'(RateHz);
      7:       word = 32'(RateHz);        // bytes per second at one byte per frame
      8:       word = 32'h0008_0001;      // one byte per frame, 8 bits
      9:       word = 32'h6174_6164;      // data
      default: word = len;
    endcase
    return word[8*(pos%4) +: 8];
  endfunction

  function automatic logic hdr_checked(input int pos);
    return (pos < 4) || (pos >= 8 && pos < 12) || (pos >= 16 && pos < LenField);
  endfunction

  // Advance the decoder mirror by one byte and collect the results it causes
  function automatic void decode_byte(input logic [7:0] b, input logic first,
                                      input logic eof, ref result_t outs[$]);
    int pos;
    int cur;
    outs.delete();
    if (first || fsm == PH_IDLE) begin
      fsm      = PH_HEADER;
      hpos     = '0;
      hbad     = 1'b0;
      dlen     = '0;
      dleft    = '0;
      prev_smp = '0;
    end
    if (fsm == PH_HEADER) begin
      pos = (int'(hpos) >= HdrBytes) ? HdrBytes - 1 : int'(hpos);
      if (hdr_checked(pos) && b != wav_hdr_byte(pos, '0)) hbad = 1'b1;
      if (pos >= LenField) dlen |= 32'(b) << (8 * (pos - LenField));
      hpos = 6'(pos + 1);
      if (pos == HdrBytes - 1) begin
        if (hbad || dlen == 0) begin
          outs.push_back('{KIND_BAD, sample_t'(0), 1'b0});
          fsm = PH_DONE;
        end else if (eof) begin
          outs.push_back('{KIND_TRUNC, sample_t'(0), 1'b0});
          fsm = PH_DONE;
        end else begin
          dleft = dlen;
          fsm   = PH_DATA;
        end
      end else if (eof) begin
        outs.push_back('{KIND_BAD, sample_t'(0), 1'b0});
        fsm = PH_DONE;
      end
    end else if (fsm == PH_DATA) begin
      cur = (int'(b) - SampleBias) * SampleScale;
      // interpolate toward the new sample except on the first data byte
      if (dleft != dlen)
        outs.push_back('{KIND_SAMPLE, sample_t'((int'(prev_smp) + cur) / 2), 1'b0});
      outs.push_back('{KIND_SAMPLE, sample_t'(cur), 1'b0});
      prev_smp = sample_t'(cur);
      dleft    = dleft - 1;
      if (dleft == 0) begin
        outs.push_back('{KIND_SAMPLE, sample_t'(cur), 1'b0});
        fsm = PH_DONE;
      end else if (eof) begin
        outs.push_back('{KIND_TRUNC, sample_t'(0), 1'b0});
        fsm = PH_DONE;
      end
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
  endfunction

  // Offer one item, wait for it to be taken, then queue what it should cause
  task automatic put_byte(input logic [7:0] b, input logic first, input logic eof,
                          input exp_mode_e mode = EXP_MODEL,
                          input kind_e kind = KIND_SAMPLE, input int smp = 0);
    result_t due[$];
    while (!calm && $urandom_range(99) < 32) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.file_byte     <= b;
    in_if.first_of_file <= first;
    in_if.end_of_file   <= eof;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) begin
      stall_cycles++;
      @(posedge clk_i);
    end
    if (fsm != PH_DONE || first) live_bytes++;
    decode_byte(b, first, eof, due);
    if (mode == EXP_NONE) begin
      due.delete();
    end else if (mode == EXP_ONE) begin
      due.delete();
      due.push_back('{kind, sample_t'(smp), 1'b1});
    end
    foreach (due[i]) exp_q.push_back(due[i]);
    results_due += due.size();
  endtask

  // Send header bytes 0..n_bytes-1, optionally corrupting one checked byte
  task automatic send_header(input logic first0, input logic [31:0] len, input int bad_pos,
                             input int n_bytes, input logic eof_last, input logic scramble);
    logic [7:0] b;
    for (int p = 0; p < n_bytes; p++) begin
      b = wav_hdr_byte(p, len);
      if (scramble && !hdr_checked(p) && p < LenField) b = 8'($urandom_range(255));
      if (p == bad_pos) b ^= 8'($urandom_range(1, 255));
      put_byte(b, (p == 0) ? first0 : 1'b0, eof_last && (p == n_bytes - 1));
    end
  endtask

  // Hold off the output for a fixed stretch once requested
  initial begin
    wait (hold_go);
    repeat (HoldCycles) @(posedge clk_i);
    hold_done <= 1'b1;
  end

  initial out_if.ready = 1'b0;

  // Check each taken result against the oldest expectation, then pick next ready
  always @(posedge clk_i) begin : rx_side
    result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (exp_q.size() == 0) begin
        if (errors < MaxReports)
          $display("unexpected result at cycle %0d: kind %0d sample %0d last %0b",
                   cycle_cnt, out_if.result_kind, out_if.sample, out_if.last_of_run);
        errors++;
      end else begin
        want = exp_q.pop_front();
        if (out_if.result_kind !== want.kind || out_if.sample !== want.smp ||
            out_if.last_of_run !== want.last) begin
          if (errors < MaxReports)
            $display("mismatch at cycle %0d: want kind %0d sample %0d last %0b, got %0d %0d %0b",
                     cycle_cnt, want.kind, want.smp, want.last,
                     out_if.result_kind, out_if.sample, out_if.last_of_run);
          errors++;
        end
        case (want.kind)
          KIND_SAMPLE: n_samples++;
          KIND_BAD:    n_bad++;
          default:     n_trunc++;
        endcase
      end
    end
    if (hold_go && !hold_done) out_if.ready <= 1'b0;
    else if (!calm && $urandom_range(99) < 32) out_if.ready <= 1'b0;
    else out_if.ready <= 1'b1;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timed out with %0d results outstanding", exp_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] len;
    int          r;
    int          bad;
    int          span;
    int          ending;
    int          base_live;
    int          base_res;
    logic        eof_last;

    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.file_byte     = '0;
    in_if.first_of_file = 1'b0;
    in_if.end_of_file   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DirRows[i]) begin
      if (DirRows[i].op == ROW_HEADER)
        send_header(DirRows[i].first, {8'h00, DirRows[i].len}, DirRows[i].bad_pos,
                    HdrBytes - 1, 1'b0, 1'b0);
      else
        put_byte(DirRows[i].b, DirRows[i].first, DirRows[i].eof, DirRows[i].mode,
                 DirRows[i].kind, DirRows[i].smp);
    end

    // Back-pressure: hold the output while full-rate bytes keep coming, then
    // drain; a second full-rate file follows with no idling on either side
    calm <= 1'b1;
    for (int f = 0; f < 2; f++) begin
      if (f == 0) hold_go <= 1'b1;
      send_header(1'b1, 32'd24 + 32'(6 * f), NoBad, HdrBytes, 1'b0, 1'b1);
      for (int i = 0; i < 24 + 6 * f; i++) put_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      while (exp_q.size() != 0) @(posedge clk_i);
    end
    calm <= 1'b0;

    // Random files: mostly well formed, some broken headers and stray bytes
    base_live = live_bytes;
    base_res  = results_due;
    while (live_bytes - base_live < RandItems || results_due - base_res < RandResults) begin
      r = $urandom_range(99);
      if (r < 65) begin
        len = ($urandom_range(7) == 0) ? $urandom() : 32'($urandom_range(1, 10));
        eof_last = ($urandom_range(24) == 0);
        send_header(1'b1, len, NoBad, HdrBytes, eof_last, 1'b1);
        if (!eof_last) begin
          // complete, cut short with end of file, or abandoned
          ending = $urandom_range(9);
          span   = (len > 10) ? $urandom_range(1, 8) : int'(len);
          if (ending >= 6) span = $urandom_range(1, span);
          eof_last = (ending < 6) ? 1'($urandom_range(1)) : (ending < 8);
          for (int i = 0; i < span; i++)
            put_byte(8'($urandom_range(255)), 1'b0, eof_last && (i == span - 1));
          if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 2))
              put_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end
      end else if (r < 85) begin
        if ($urandom_range(1) == 1) begin
          do bad = $urandom_range(LenField - 1); while (!hdr_checked(bad));
          len = 32'($urandom_range(1, 10));
          if ($urandom_range(3) == 0) begin
            bad = NoBad;
            len = '0;
          end
          send_header(1'b1, len, bad, HdrBytes, 1'($urandom_range(1)), 1'b1);
        end else begin
          send_header(1'b1, $urandom(), NoBad, $urandom_range(1, HdrBytes - 1), 1'b1, 1'b1);
        end
      end else begin
        repeat ($urandom_range(1, 5))
          put_byte(8'($urandom_range(255)), $urandom_range(3) == 0, $urandom_range(3) == 0);
      end
    end

    // Drain
    in_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("decoded %0d live file bytes into %0d samples, %0d header rejects, %0d truncations",
             live_bytes, n_samples, n_bad, n_trunc);
    $display("input held back for %0d cycles by output back-pressure", stall_cycles);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
